@@ hdl/ssdw_pkg.sv @@
// Package for the seven-segment digit word generator.
// Holds constants, the segment pattern table and the front-to-back queue entry type.
// No dependencies.
package ssdw_pkg;

    localparam int unsigned VALUE_W     = 17;
    localparam int unsigned CLOCK_W     = 13;
    localparam int unsigned MINS_W      = 7;
    localparam int unsigned QUOT_W      = 14;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned STEP_W      = 3;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [VALUE_W-1:0] DECIMAL_MAX = 17'd99999;
    localparam logic [CLOCK_W-1:0] CLOCK_MAX   = 13'd5999;

    // Reciprocal multipliers: x / 10 = (x * 209716) >> 21 for x < 2^18,
    // x / 60 = (x * 17477) >> 20 for x < 2^14.
    localparam logic [17:0] DIV10_MUL   = 18'd209716;
    localparam int unsigned DIV10_SHIFT = 21;
    localparam logic [14:0] DIV60_MUL   = 15'd17477;
    localparam int unsigned DIV60_SHIFT = 20;

    localparam logic [DIGIT_W-1:0] COLON_INDEX    = 4'd10;
    localparam logic [STEP_W-1:0]  COLON_STEP     = 3'd2;
    localparam logic [STEP_W-1:0]  LAST_STEP      = 3'd4;
    localparam logic [7:0]         FIRST_POSITION = 8'h80;

    typedef enum logic {
        MODE_DECIMAL = 1'b0,
        MODE_CLOCK   = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [VALUE_W-1:0] val;
        logic [MINS_W-1:0]  mins;
    } t_q_entry;

    function automatic logic [7:0] seg_pattern(input logic [DIGIT_W-1:0] idx);
        logic [7:0] pat;
        case (idx)
            4'd0:    pat = 8'hAF;
            4'd1:    pat = 8'hA0;
            4'd2:    pat = 8'h6E;
            4'd3:    pat = 8'hEA;
            4'd4:    pat = 8'hE1;
            4'd5:    pat = 8'hCB;
            4'd6:    pat = 8'hCF;
            4'd7:    pat = 8'hA2;
            4'd8:    pat = 8'hEF;
            4'd9:    pat = 8'hEB;
            default: pat = 8'h40;
        endcase
        return pat;
    endfunction

endpackage

@@ hdl/ssdw_front.sv @@
// Front stage: holds the display mode, accepts values, clamps them and splits clock values.
// Depends on ssdw_pkg.
module ssdw_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_display_mode,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ssdw_pkg::VALUE_W-1:0] i_display_value,
    output logic                       o_q_valid,
    input  logic                       i_q_ready,
    output ssdw_pkg::t_q_entry         o_q_entry
);
    import ssdw_pkg::*;

    t_mode              r_mode;
    logic               r_valid;
    logic               n_valid;
    t_q_entry           r_entry;
    t_q_entry           n_entry;
    logic               w_accept;
    logic [CLOCK_W-1:0] w_clk_val;
    logic [27:0]        w_prod;
    logic [MINS_W-1:0]  w_mins;
    logic [CLOCK_W-1:0] w_mins60;
    logic [CLOCK_W-1:0] w_secs;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_valid || i_q_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_q_valid   = r_valid;
    assign o_q_entry   = r_entry;

    // Clamp and split into minutes and seconds for clock mode.
    always_comb begin
        if (i_display_value > VALUE_W'(CLOCK_MAX)) begin
            w_clk_val = CLOCK_MAX;
        end else begin
            w_clk_val = i_display_value[CLOCK_W-1:0];
        end
        w_prod   = 28'(w_clk_val) * 28'(DIV60_MUL);
        w_mins   = w_prod[DIV60_SHIFT +: MINS_W];
        w_mins60 = (CLOCK_W'(w_mins) << 6) - (CLOCK_W'(w_mins) << 2);
        w_secs   = w_clk_val - w_mins60;
    end

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (w_accept) begin
            n_valid      = 1'b1;
            n_entry.mode = r_mode;
            if (r_mode == MODE_CLOCK) begin
                n_entry.val  = VALUE_W'(w_secs);
                n_entry.mins = w_mins;
            end else begin
                n_entry.val  = (i_display_value > DECIMAL_MAX) ? DECIMAL_MAX : i_display_value;
                n_entry.mins = '0;
            end
        end else if (i_q_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_DECIMAL;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= t_mode'(i_display_mode);
            end
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

@@ hdl/ssdw_queue.sv @@
// Short queue between front and back stages.
// Depends on ssdw_pkg.
module ssdw_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_valid,
    output logic               o_wr_ready,
    input  ssdw_pkg::t_q_entry i_wr_entry,
    output logic               o_rd_valid,
    input  logic               i_rd_ready,
    output ssdw_pkg::t_q_entry o_rd_entry
);
    import ssdw_pkg::*;

    t_q_entry r_mem [QUEUE_DEPTH];
    logic     r_wr_ptr;
    logic     r_rd_ptr;
    logic [1:0] r_count;
    logic     w_push;
    logic     w_pop;

    assign o_wr_ready = (r_count != 2'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_entry = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

endmodule

@@ hdl/ssdw_back.sv @@
// Back stage: peels one digit per cycle unless stalled, into the registered output.
// Depends on ssdw_pkg.
module ssdw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  ssdw_pkg::t_q_entry i_q_entry,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_position_byte,
    output logic [7:0]         o_segment_byte,
    output logic               o_last_digit
);
    import ssdw_pkg::*;

    logic               r_busy;
    logic [STEP_W-1:0]  r_step;
    t_mode              r_mode;
    logic [VALUE_W-1:0] r_val;
    logic [MINS_W-1:0]  r_mins;
    logic               r_out_valid;
    logic [7:0]         r_pos;
    logic [7:0]         r_seg;
    logic               r_last;

    logic               w_adv;
    logic               w_load;
    logic [34:0]        w_prod;
    logic [QUOT_W-1:0]  w_quot;
    logic [VALUE_W-1:0] w_quot10;
    logic [VALUE_W-1:0] w_rem;
    logic [DIGIT_W-1:0] w_digit;
    logic [VALUE_W-1:0] n_val;
    logic               w_colon;

    assign w_adv     = r_busy && (!r_out_valid || i_out_ready);
    assign w_load    = i_q_valid && (!r_busy || (w_adv && r_step == LAST_STEP));
    assign o_q_ready = w_load;

    assign o_out_valid     = r_out_valid;
    assign o_position_byte = r_pos;
    assign o_segment_byte  = r_seg;
    assign o_last_digit    = r_last;

    // One decimal digit per step; the colon step reloads the minutes.
    always_comb begin
        w_prod   = 35'(r_val) * 35'(DIV10_MUL);
        w_quot   = w_prod[DIV10_SHIFT +: QUOT_W];
        w_quot10 = (VALUE_W'(w_quot) << 3) + (VALUE_W'(w_quot) << 1);
        w_rem    = r_val - w_quot10;
        w_colon  = (r_mode == MODE_CLOCK) && (r_step == COLON_STEP);
        if (w_colon) begin
            w_digit = COLON_INDEX;
            n_val   = VALUE_W'(r_mins);
        end else begin
            w_digit = w_rem[DIGIT_W-1:0];
            n_val   = VALUE_W'(w_quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (w_adv) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mode <= i_q_entry.mode;
            r_val  <= i_q_entry.val;
            r_mins <= i_q_entry.mins;
        end else if (w_adv) begin
            r_val <= n_val;
        end
        if (w_adv) begin
            r_pos  <= FIRST_POSITION >> r_step;
            r_seg  <= seg_pattern(w_digit);
            r_last <= (r_step == LAST_STEP);
        end
    end

endmodule

@@ hdl/seven_segment_digit_words.sv @@
// Top level of the seven-segment digit word generator.
// Depends on ssdw_pkg, ssdw_front, ssdw_queue and ssdw_back.
//
// Each value accepted gives five digit words, units first (position 0x80 down to 0x08),
// the fifth marked last. The back stage's divide-by-ten unit produces one word per cycle
// unless the output stalls; the front stage and a two-entry queue keep accepting
// values while the back stage works. A value passes the front stage register, the queue,
// the back stage's value registers and then its output registers. Mode 0 shows five
// decimal digits clamped at 99999; mode 1 shows minutes, colon, seconds clamped at 99:59.
module seven_segment_digit_words (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_display_mode,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ssdw_pkg::VALUE_W-1:0] i_display_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_position_byte,
    output logic [7:0]                   o_segment_byte,
    output logic                         o_last_digit
);
    import ssdw_pkg::*;

    logic     w_fq_valid;
    logic     w_fq_ready;
    t_q_entry w_fq_entry;
    logic     w_qb_valid;
    logic     w_qb_ready;
    t_q_entry w_qb_entry;

    ssdw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_display_mode  (i_display_mode),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_display_value (i_display_value),
        .o_q_valid       (w_fq_valid),
        .i_q_ready       (w_fq_ready),
        .o_q_entry       (w_fq_entry)
    );

    ssdw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fq_valid),
        .o_wr_ready (w_fq_ready),
        .i_wr_entry (w_fq_entry),
        .o_rd_valid (w_qb_valid),
        .i_rd_ready (w_qb_ready),
        .o_rd_entry (w_qb_entry)
    );

    ssdw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_qb_valid),
        .o_q_ready       (w_qb_ready),
        .i_q_entry       (w_qb_entry),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_position_byte (o_position_byte),
        .o_segment_byte  (o_segment_byte),
        .o_last_digit    (o_last_digit)
    );

endmodule
